FILE: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked on clk, off while arst_n is low
`define CAF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// implication into the next cycle, checked on clk, off while arst_n is low
`define CAF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

FILE: rtl/caf_pkg.sv
// package with types and constants of the can identifier acceptance filter
package caf_pkg;

	// number of table entries, one cell each
	localparam int SLOTS = 16;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_MATCH  = 2'd3
	} caf_op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} caf_status_t;

	// input transaction
	typedef struct packed {
		caf_op_t     opcode;
		logic        is_extended;
		logic [10:0] base_id;
		logic [17:0] extension_id;
	} caf_item_t;

	// result transaction
	typedef struct packed {
		logic        accepted;
		caf_status_t status;
		logic        table_full;
		logic        table_empty;
	} caf_result_t;

	// controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic add_go;
		logic rem_go;
		logic clear;
	} caf_ctl_t;

endpackage

FILE: rtl/caf_cell.sv
// one table entry of the filter chain with its compare and priority links
module caf_cell
	import caf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  caf_item_t cmd,
	input  caf_ctl_t  ctl,
	input  logic      free_in,
	input  logic      hit_in,
	output logic      free_out,
	output logic      hit_out,
	output logic      used,
	output logic      used_nxt
);

	logic        used_q;
	logic        hit_q;
	logic        ext_q;
	logic [10:0] base_q;
	logic [17:0] ext_id_q;
	logic        key_eq;
	logic        first_free;
	logic        first_hit;
	logic        do_add;
	logic        do_free;

	// exact compare of the stored entry against the command key
	assign key_eq = used_q && (ext_q == cmd.is_extended) && (base_q == cmd.base_id) &&
		(!cmd.is_extended || (ext_id_q == cmd.extension_id));

	// priority links: a lower cell already free or already hit
	assign free_out   = free_in | ~used_q;
	assign hit_out    = hit_in | hit_q;
	assign first_free = ~used_q & ~free_in;
	assign first_hit  = hit_q & ~hit_in;

	// write decisions for this entry
	assign do_add  = ctl.add_go & first_free;
	assign do_free = ctl.clear | (ctl.rem_go & first_hit);

	always_comb begin
		used_nxt = used_q;
		if (do_free) begin
			used_nxt = 1'b0;
		end else if (do_add) begin
			used_nxt = 1'b1;
		end
	end

	assign used = used_q;

	// control state of the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			used_q <= used_nxt;
			if (ctl.cmp_en) begin
				hit_q <= key_eq;
			end
		end
	end

	// stored identifier, zeroed when the entry is freed
	always_ff @(posedge clk) begin
		if (do_free) begin
			ext_q    <= 1'b0;
			base_q   <= '0;
			ext_id_q <= '0;
		end else if (do_add) begin
			ext_q    <= cmd.is_extended;
			base_q   <= cmd.base_id;
			ext_id_q <= cmd.extension_id;
		end
	end

endmodule

FILE: rtl/can_id_acceptance_filter_top.sv
// top level of the can identifier acceptance filter: sequencer and row of entry cells
// done is registered at the end of the update state, which follows the compare state entered on start
// a new start is taken only while busy is low; busy is high through the compare and update states
// the compare state compares every cell against the key, the update state runs the priority chain and writes
// the result cannot be stalled: done marks it for exactly one cycle
// reset: asynchronous, active low arst_n, leaves every entry free and the block idle
module can_id_acceptance_filter_top
	import caf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  caf_item_t   item,
	output logic        done,
	output caf_result_t result
);

`include "assert_macros.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	state_t      state_q;
	logic        done_q;
	caf_result_t result_q;
	caf_item_t   cmd_q;
	caf_ctl_t    ctl;
	logic        accept;

	logic [SLOTS:0]   free_c;
	logic [SLOTS:0]   hit_c;
	logic [SLOTS-1:0] used_vec;
	logic [SLOTS-1:0] used_nxt_vec;

	logic        full_before;
	logic        empty_before;
	logic        any_hit;
	logic        acc_d;
	caf_status_t status_d;

	assign accept = start & ~busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// command register, standard identifiers carry a zero extension
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.opcode       <= item.opcode;
			cmd_q.is_extended  <= item.is_extended;
			cmd_q.base_id      <= item.base_id;
			cmd_q.extension_id <= item.is_extended ? item.extension_id : '0;
		end
	end

	// row of entry cells, priority links run from entry zero upwards
	assign free_c[0] = 1'b0;
	assign hit_c[0]  = 1'b0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		caf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd_q),
			.ctl      (ctl),
			.free_in  (free_c[g]),
			.hit_in   (hit_c[g]),
			.free_out (free_c[g+1]),
			.hit_out  (hit_c[g+1]),
			.used     (used_vec[g]),
			.used_nxt (used_nxt_vec[g])
		);
	end

	// table state before the operation
	assign full_before  = ~free_c[SLOTS];
	assign any_hit      = hit_c[SLOTS];
	assign empty_before = ~(|used_vec);

	// compare enable in the compare state, operation decode in the update state
	always_comb begin
		ctl        = '0;
		ctl.cmp_en = (state_q == S_CMP);
		status_d   = ST_OK;
		acc_d      = 1'b0;
		if (state_q == S_UPD) begin
			case (cmd_q.opcode)
				OP_CLEAR: begin
					ctl.clear = 1'b1;
				end
				OP_ADD: begin
					if (full_before) begin
						status_d = ST_FULL;
					end else if (any_hit) begin
						status_d = ST_PRESENT;
					end else begin
						ctl.add_go = 1'b1;
					end
				end
				OP_REMOVE: begin
					if (empty_before) begin
						status_d = ST_EMPTY;
					end else if (!any_hit) begin
						status_d = ST_NOT_FOUND;
					end else begin
						ctl.rem_go = 1'b1;
					end
				end
				OP_MATCH: begin
					acc_d = any_hit;
				end
				default: begin
					status_d = ST_OK;
				end
			endcase
		end
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q              <= S_IDLE;
					done_q               <= 1'b1;
					result_q.accepted    <= acc_d;
					result_q.status      <= status_d;
					result_q.table_full  <= &used_nxt_vec;
					result_q.table_empty <= ~(|used_nxt_vec);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`CAF_ASSERT_IMP(a_done_after_start, accept, ##3 done, "result strobe missing after start")
	`CAF_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`CAF_ASSERT_IMP(a_flag_excl, done, !(result.table_full && result.table_empty), "flags clash")
	`CAF_ASSERT_IMP(a_add_legal, ctl.add_go, (!full_before && !any_hit), "illegal add")

endmodule

FILE: sim/can_id_acceptance_filter_top_tb.sv
// testbench for the can identifier acceptance filter: exact-match table checked against a predictor
`timescale 1ns / 1ps

module can_id_acceptance_filter_top_tb;
	import caf_pkg::*;

	// table predictor and queue of results still owed by the block
	class caf_filter_scoreboard;
		logic        used_q [SLOTS];
		logic [10:0] base_q [SLOTS];
		logic        ext_q [SLOTS];
		logic [17:0] extid_q [SLOTS];
		caf_result_t pending_results [$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			for (int i = 0; i < SLOTS; i++) begin
				free_entry(i);
			end
		endfunction

		function void free_entry(int i);
			used_q[i]  = 1'b0;
			base_q[i]  = '0;
			ext_q[i]   = 1'b0;
			extid_q[i] = '0;
		endfunction

		// lowest used entry of the same kind with equal identifier parts
		function int lookup(logic x, logic [10:0] b, logic [17:0] e);
			for (int i = 0; i < SLOTS; i++) begin
				if (used_q[i] && ext_q[i] == x && base_q[i] == b && (!x || extid_q[i] == e)) begin
					return i;
				end
			end
			return -1;
		endfunction

		function int first_free();
			for (int i = 0; i < SLOTS; i++) begin
				if (!used_q[i]) begin
					return i;
				end
			end
			return -1;
		endfunction

		function int occupancy();
			int n;
			n = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (used_q[i]) begin
					n++;
				end
			end
			return n;
		endfunction

		// apply one accepted command to the table and queue its result
		function void note_item(caf_item_t it);
			caf_result_t r;
			int          slot;
			logic [17:0] key_ext;
			key_ext  = it.is_extended ? it.extension_id : '0;
			r        = '0;
			r.status = ST_OK;
			case (it.opcode)
				OP_CLEAR: begin
					for (int i = 0; i < SLOTS; i++) begin
						free_entry(i);
					end
				end
				OP_ADD: begin
					// fullness is tested before presence
					slot = first_free();
					if (slot < 0) begin
						r.status = ST_FULL;
					end else if (lookup(it.is_extended, it.base_id, key_ext) >= 0) begin
						r.status = ST_PRESENT;
					end else begin
						used_q[slot]  = 1'b1;
						base_q[slot]  = it.base_id;
						ext_q[slot]   = it.is_extended;
						extid_q[slot] = key_ext;
					end
				end
				OP_REMOVE: begin
					// emptiness is tested before presence
					if (occupancy() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						slot = lookup(it.is_extended, it.base_id, key_ext);
						if (slot < 0) begin
							r.status = ST_NOT_FOUND;
						end else begin
							free_entry(slot);
						end
					end
				end
				default: begin
					r.accepted = (lookup(it.is_extended, it.base_id, key_ext) >= 0);
				end
			endcase
			r.table_full  = (occupancy() == SLOTS);
			r.table_empty = (occupancy() == 0);
			pending_results.push_back(r);
		endfunction

		function void report(string what, caf_result_t want, caf_result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s: expected acc=%0b st=%0d full=%0b empty=%0b",
					$time, what, want.accepted, want.status, want.table_full,
					want.table_empty);
				$display("%0t %s: got      acc=%0b st=%0d full=%0b empty=%0b",
					$time, what, got.accepted, got.status, got.table_full,
					got.table_empty);
			end
		endfunction

		// compare one result transaction with the oldest expectation
		function void check_result(caf_result_t got);
			caf_result_t want;
			if (pending_results.size() == 0) begin
				report("result with nothing expected", '0, got);
				return;
			end
			want = pending_results.pop_front();
			if (got.accepted !== want.accepted || got.status !== want.status ||
				got.table_full !== want.table_full || got.table_empty !== want.table_empty) begin
				report("result mismatch", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	caf_item_t   item;
	logic        done;
	caf_result_t result;

	caf_filter_scoreboard filter_sb = new();
	caf_item_t            id_pool [24];
	logic                 burst_idle;

	can_id_acceptance_filter_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// clock, 10 ns period
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// reset held low at the start, released on a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			filter_sb.check_result(result);
		end
	end

	// watchdog
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic caf_item_t random_id();
		caf_item_t c;
		c              = '0;
		c.is_extended  = 1'($urandom_range(0, 1));
		c.base_id      = 11'($urandom_range(0, 2047));
		c.extension_id = 18'($urandom_range(0, 262143));
		return c;
	endfunction

	function automatic caf_item_t mk(caf_op_t op, logic x, logic [10:0] b, logic [17:0] e);
		caf_item_t c;
		c.opcode       = op;
		c.is_extended  = x;
		c.base_id      = b;
		c.extension_id = e;
		return c;
	endfunction

	// identifier pool with the extremes and a base shared by both kinds
	function automatic void refresh_pool();
		for (int i = 0; i < 24; i++) begin
			id_pool[i] = random_id();
		end
		id_pool[0] = mk(OP_ADD, 1'b0, 11'h000, 18'h00000);
		id_pool[1] = mk(OP_ADD, 1'b1, 11'h7ff, 18'h3ffff);
		id_pool[2] = mk(OP_ADD, 1'b1, 11'h000, 18'h00000);
		id_pool[3] = mk(OP_ADD, 1'b0, 11'h7ff, 18'h00000);
		id_pool[4] = id_pool[5];
		id_pool[4].is_extended = ~id_pool[5].is_extended;
	endfunction

	// mostly pool identifiers, some fresh ones and near misses
	function automatic caf_item_t random_command();
		caf_item_t c;
		int        roll;
		int        pick;
		int        bit_idx;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		c    = id_pool[$urandom_range(0, 23)];
		case (pick)
			6: c = random_id();
			7: begin
				bit_idx = $urandom_range(0, 17);
				c.extension_id[bit_idx] = ~c.extension_id[bit_idx];
			end
			8: c.is_extended = ~c.is_extended;
			9: begin
				bit_idx = $urandom_range(0, 10);
				c.base_id[bit_idx] = ~c.base_id[bit_idx];
			end
			default: ;
		endcase
		if (!c.is_extended) begin
			c.extension_id = 18'($urandom_range(0, 262143));
		end
		if (roll < 2) begin
			c.opcode = OP_CLEAR;
		end else if (roll < 45) begin
			c.opcode = OP_ADD;
		end else if (roll < 70) begin
			c.opcode = OP_REMOVE;
		end else begin
			c.opcode = OP_MATCH;
		end
		return c;
	endfunction

	function automatic int draw_gap();
		return burst_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// entered and left on a falling edge; one start assignment per edge
	task automatic issue(caf_item_t it, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do begin
			@(posedge clk);
		end while (busy);
		filter_sb.note_item(it);
		@(negedge clk);
	endtask

	// hold off until every outstanding result has arrived
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (filter_sb.pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// stimulus
	initial begin
		start      = 1'b0;
		item       = '0;
		burst_idle = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// directed transactions
		issue(mk(OP_REMOVE, 1'b0, 11'h005, 18'h00000), draw_gap());
		issue(mk(OP_MATCH,  1'b0, 11'h005, 18'h00000), draw_gap());
		issue(mk(OP_ADD,    1'b0, 11'h000, 18'h3ffff), draw_gap());
		issue(mk(OP_ADD,    1'b0, 11'h000, 18'h00000), draw_gap());
		issue(mk(OP_ADD,    1'b1, 11'h000, 18'h00000), draw_gap());
		issue(mk(OP_ADD,    1'b1, 11'h7ff, 18'h3ffff), draw_gap());
		issue(mk(OP_ADD,    1'b1, 11'h7ff, 18'h3fffe), draw_gap());
		issue(mk(OP_MATCH,  1'b0, 11'h000, 18'h12345), draw_gap());
		issue(mk(OP_MATCH,  1'b1, 11'h7ff, 18'h3ffff), draw_gap());
		issue(mk(OP_MATCH,  1'b1, 11'h7ff, 18'h1ffff), draw_gap());
		issue(mk(OP_MATCH,  1'b0, 11'h7ff, 18'h3ffff), draw_gap());
		issue(mk(OP_REMOVE, 1'b1, 11'h7ff, 18'h00000), draw_gap());
		issue(mk(OP_REMOVE, 1'b0, 11'h000, 18'h2aaaa), draw_gap());
		issue(mk(OP_ADD,    1'b0, 11'h7ff, 18'h15555), draw_gap());
		issue(mk(OP_ADD,    1'b1, 11'h000, 18'h00000), draw_gap());
		issue(mk(OP_CLEAR,  1'b1, 11'h7ff, 18'h3ffff), draw_gap());
		issue(mk(OP_MATCH,  1'b1, 11'h000, 18'h00000), draw_gap());
		issue(mk(OP_ADD,    1'b0, 11'h555, 18'h15555), draw_gap());
		issue(mk(OP_ADD,    1'b1, 11'h2aa, 18'h2aaaa), draw_gap());
		issue(mk(OP_REMOVE, 1'b1, 11'h2aa, 18'h2aaaa), draw_gap());
		issue(mk(OP_CLEAR,  1'b0, 11'h000, 18'h00000), draw_gap());
		drain();

		// random transactions in bursts, some bursts without idle cycles
		for (int n = 0; n < 1600; n++) begin
			if (n % 400 == 0) begin
				refresh_pool();
			end
			if (n % 100 == 0) begin
				burst_idle = ($urandom_range(0, 2) == 0);
			end
			if (n == 800) begin
				drain();
			end
			issue(random_command(), draw_gap());
		end

		drain();
		repeat (8) @(posedge clk);
		if (filter_sb.mismatches == 0 && filter_sb.pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
